/* hdl/thtcc_pkg.sv */
// Package for the typed handle table: table size, field widths, command,
// kind and status codes, the table entry type and the sequencer states.
// No dependencies.
package thtcc_pkg;

  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CMP_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

  localparam logic [CMD_W-1:0] CMD_SET_AT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MAP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PERF   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PROG   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LINK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OTHER  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OCCUPIED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_KIND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] prog;
    logic [SLOT_W-1:0] tgt;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_CASC,
    ST_FIN,
    ST_WIPE
  } state_e;

endpackage

/* hdl/typed_handle_table_with_cascade_clear_top.sv */
// Typed handle table top level: slot memory, command sequencer and result register.
// Depends on thtcc_pkg.
//
// A request is taken when start_i is high and busy_o is low; each request gives exactly
// one result, shown for one cycle with done_o high, and the receiver cannot stall it.
// All slots live in one single-port-read, single-port-write memory with a registered
// read, so timing follows the number of entries the sequencer must visit, one per cycle:
// set at a slot, clear of a map/link/other slot and read look the slot up once and then
// answer; a request whose slot lies beyond the table answers from idle with no lookup;
// set at lowest free scans from slot 0 up to the first free one, or the whole table when
// full; clear of a program or perf-event slot sweeps the whole table for links; clear
// all writes every entry. After reset the block clears the memory with busy_o high.
module typed_handle_table_with_cascade_clear_top
  import thtcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [KIND_W-1:0] entry_kind_i,
  input  logic [SLOT_W-1:0] link_program_i,
  input  logic [SLOT_W-1:0] link_target_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [SLOT_W-1:0] slot_used_o,
  output logic [KIND_W-1:0] kind_read_o,
  output logic [SLOT_W-1:0] program_read_o,
  output logic [SLOT_W-1:0] target_read_o
);

  entry_t mem_q [SLOTS];
  entry_t rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [SLOT_W-1:0] prog_q, prog_d;
  logic [SLOT_W-1:0] tgt_q, tgt_d;
  logic              casc_prog_q, casc_prog_d;

  logic              done_q, done_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0] used_q, used_d;
  entry_t            res_q, res_d;

  logic              idx_last;
  logic              in_range_i;
  logic [IDX_W-1:0]  slot_idx_i, slot_idx_q;
  logic [IDX_W-1:0]  idx_inc;
  logic              casc_hit;
  logic              link_match;
  logic [STAT_W-1:0] set_status;
  entry_t            new_entry;
  entry_t            set_view;

  assign idx_last   = (idx_q == IDX_W'(SLOTS - 1));
  assign idx_inc    = idx_q + 1'b1;
  assign in_range_i = (CMP_W'(slot_i) < CMP_W'(SLOTS));
  assign slot_idx_i = IDX_W'(slot_i);
  assign slot_idx_q = IDX_W'(slot_q);
  assign casc_hit   = (rdata_q.kind == KIND_PROG) || (rdata_q.kind == KIND_PERF);
  assign link_match = (rdata_q.kind == KIND_LINK) &&
                      (casc_prog_q ? (rdata_q.prog == slot_q) : (rdata_q.tgt == slot_q));

  always_comb begin
    if (rdata_q.kind != KIND_UNUSED) begin
      set_status = STAT_OCCUPIED;
    end else if (kind_q == KIND_UNUSED || kind_q > KIND_OTHER) begin
      set_status = STAT_BAD_KIND;
    end else begin
      set_status = STAT_OK;
    end
    new_entry.kind = kind_q;
    new_entry.prog = (kind_q == KIND_LINK) ? prog_q : '0;
    new_entry.tgt  = (kind_q == KIND_LINK) ? tgt_q : '0;
    set_view       = (set_status == STAT_OK) ? new_entry : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (idx_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_i)
            CMD_SET_FREE:  state_d = ST_SCAN;
            CMD_CLEAR_ALL: state_d = ST_WIPE;
            default: begin
              if (in_range_i) state_d = ST_LOOK;
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (cmd_q == CMD_CLEAR && casc_hit) state_d = ST_CASC;
        else state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (rdata_q.kind == KIND_UNUSED || idx_last) state_d = ST_IDLE;
      end
      ST_CASC: begin
        if (idx_last) state_d = ST_FIN;
      end
      ST_FIN:  state_d = ST_IDLE;
      ST_WIPE: begin
        if (idx_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_raddr   = idx_inc;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    kind_d      = kind_q;
    prog_d      = prog_q;
    tgt_d       = tgt_q;
    casc_prog_d = casc_prog_q;
    done_d      = 1'b0;
    status_d    = status_q;
    used_d      = used_q;
    res_d       = res_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d  = cmd_i;
          slot_d = slot_i;
          kind_d = entry_kind_i;
          prog_d = link_program_i;
          tgt_d  = link_target_i;
          idx_d  = '0;
          if (cmd_i == CMD_SET_FREE) begin
            mem_raddr = '0;
          end else begin
            mem_raddr = slot_idx_i;
          end
          if (cmd_i != CMD_SET_FREE && cmd_i != CMD_CLEAR_ALL && !in_range_i) begin
            done_d   = 1'b1;
            status_d = (cmd_i == CMD_SET_AT) ? STAT_FULL : STAT_OK;
            used_d   = slot_i;
            res_d    = '0;
          end
        end
      end
      ST_LOOK: begin
        case (cmd_q)
          CMD_SET_AT: begin
            mem_we    = (set_status == STAT_OK);
            mem_waddr = slot_idx_q;
            mem_wdata = new_entry;
            done_d    = 1'b1;
            status_d  = set_status;
            used_d    = slot_q;
            res_d     = set_view;
          end
          CMD_CLEAR: begin
            if (casc_hit) begin
              mem_raddr   = '0;
              idx_d       = '0;
              casc_prog_d = (rdata_q.kind == KIND_PROG);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_idx_q;
              done_d    = 1'b1;
              status_d  = STAT_OK;
              used_d    = slot_q;
              res_d     = '0;
            end
          end
          default: begin
            done_d   = 1'b1;
            status_d = STAT_OK;
            used_d   = slot_q;
            res_d    = rdata_q;
          end
        endcase
      end
      ST_SCAN: begin
        if (rdata_q.kind == KIND_UNUSED) begin
          mem_we    = (set_status == STAT_OK);
          mem_wdata = new_entry;
          done_d    = 1'b1;
          status_d  = set_status;
          used_d    = SLOT_W'(idx_q);
          res_d     = set_view;
        end else if (idx_last) begin
          done_d   = 1'b1;
          status_d = STAT_FULL;
          used_d   = '0;
          res_d    = '0;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_CASC: begin
        mem_we = link_match;
        idx_d  = idx_inc;
      end
      ST_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = slot_idx_q;
        done_d    = 1'b1;
        status_d  = STAT_OK;
        used_d    = slot_q;
        res_d     = '0;
      end
      ST_WIPE: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
        if (idx_last) begin
          done_d   = 1'b1;
          status_d = STAT_OK;
          used_d   = '0;
          res_d    = '0;
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    slot_q      <= slot_d;
    kind_q      <= kind_d;
    prog_q      <= prog_d;
    tgt_q       <= tgt_d;
    casc_prog_q <= casc_prog_d;
    status_q    <= status_d;
    used_q      <= used_d;
    res_q       <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_used_o    = used_q;
  assign kind_read_o    = res_q.kind;
  assign program_read_o = res_q.prog;
  assign target_read_o  = res_q.tgt;

endmodule
